### hdl/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg: shared constants for the indexed min-heap
// Widths of node ids, slots, costs and request codes.
// ----------------------------------------------------------------------------
package imh_pkg;
    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = 10;
    localparam int SLOT_W    = 10;
    localparam int CNT_W     = 11;
    localparam int COST_W    = 31;
    localparam logic [COST_W-1:0] COST_INF = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        REQ_INIT  = 2'd0,
        REQ_DEC   = 2'd1,
        REQ_EXT   = 2'd2,
        REQ_QUERY = 2'd3
    } t_req;
endpackage

### hdl/indexed_min_heap_decrease_key.sv
// Query and rejected decrease: one position-map read, then the result. Empty extract goes
// straight to the result. Decrease sifts up level by level toward the root; extract moves the
// last pair to the root and sifts it down level by level. Init: one memory sweep.
// Throughput: one request at a time; the next is taken after the result transfer.
// Reset: synchronous active low; runs the identity sweep before
// the first request is taken, heap empty, node_count 1024.
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key
// Indexed binary min-heap with init, decrease-key, extract-min and membership query.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [9:0]  i_node_id,
    input  logic [30:0] i_new_cost,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_out_node_id,
    output logic [30:0] o_out_cost,
    output logic        o_found,
    output logic        o_heap_empty,
    output logic        o_rejected
);
    localparam int SW = imh_pkg::SLOT_W;
    localparam int NW = imh_pkg::NODE_W;
    localparam int CW = imh_pkg::COST_W;
    localparam int KW = imh_pkg::CNT_W;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_POS_RD, S_POS_WT, S_DEC_WR,
        S_UP_RD, S_UP_WT, S_UP_CMP,
        S_EX_RD, S_EX_WT, S_EX_LAST, S_EX_LWT, S_EX_SWAP,
        S_DN_RD, S_DN_LWT, S_DN_RWT, S_DN_CMP,
        S_OUT
    } t_state;

    // heap memory: {node, cost} per slot; position map node -> slot
    logic [NW+CW-1:0] heap_mem [imh_pkg::MAX_NODES];
    logic [SW-1:0]    pos_mem  [imh_pkg::MAX_NODES];

    logic          h_we, p_we;
    logic [SW-1:0] h_wa, h_ra, p_wa, p_ra;
    logic [NW+CW-1:0] h_wd, h_rd;
    logic [SW-1:0] p_wd, p_rd;

    always_ff @(posedge i_clk) begin
        if (h_we)  heap_mem[h_wa]  <= h_wd;
        h_rd <= heap_mem[h_ra];
    end
    always_ff @(posedge i_clk) begin
        if (p_we)  pos_mem[p_wa]  <= p_wd;
        p_rd <= pos_mem[p_ra];
    end

    t_state r_state;
    logic [KW-1:0] r_ncfg, r_cnt, r_clr;
    logic [1:0]    r_req;
    logic [NW-1:0] r_id;
    logic [CW-1:0] r_cost;
    logic [SW-1:0] r_s;          // current slot
    logic [NW-1:0] r_cur_n;      // pair being sifted
    logic [CW-1:0] r_cur_c;
    logic [NW+CW-1:0] r_l, r_oth; // left child / other pair
    logic          r_has_l, r_has_r;
    logic          r_ov;
    logic [NW-1:0] r_on;
    logic [CW-1:0] r_oc;
    logic          r_of, r_oe, r_or;

    logic [SW-1:0] par;
    logic [SW:0]   lch, rch;
    assign par = (r_s - 1'b1) >> 1;
    assign lch = {r_s, 1'b1};
    assign rch = {r_s, 1'b0} + 2'd2;

    assign o_stall = (r_state != S_IDLE) || r_ov;
    assign o_valid = r_ov;
    assign o_out_node_id = r_on;
    assign o_out_cost = r_oc;
    assign o_found = r_of;
    assign o_heap_empty = r_oe;
    assign o_rejected = r_or;

    logic [CW-1:0] h_rc;
    logic [NW-1:0] h_rn;
    assign h_rc = h_rd[CW-1:0];
    assign h_rn = h_rd[NW+CW-1:CW];

    always_comb begin
        h_we = 1'b0; h_wa = r_s; h_wd = {r_cur_n, r_cur_c};
        p_we = 1'b0; p_wa = r_cur_n; p_wd = r_s;
        h_ra = r_s; p_ra = r_id;
        unique case (r_state)
            S_CLR: begin
                h_we = 1'b1; h_wa = r_clr[SW-1:0];
                h_wd = {r_clr[NW-1:0], imh_pkg::COST_INF};
                p_we = 1'b1; p_wa = r_clr[SW-1:0]; p_wd = r_clr[SW-1:0];
            end
            S_IDLE: p_ra = i_node_id;
            S_DEC_WR, S_EX_SWAP: begin
                h_we = (r_state == S_DEC_WR) ? 1'b0 : 1'b1;
            end
            S_UP_RD, S_UP_WT: h_ra = par;
            S_UP_CMP: begin
                if (r_s != '0 && h_rc > r_cur_c) begin
                    // parent moves down into current slot
                    h_we = 1'b1; h_wa = r_s; h_wd = h_rd;
                    p_we = 1'b1; p_wa = h_rn; p_wd = r_s;
                end else begin
                    h_we = 1'b1; h_wa = r_s; h_wd = {r_cur_n, r_cur_c};
                    p_we = 1'b1; p_wa = r_cur_n; p_wd = r_s;
                end
            end
            S_EX_RD: h_ra = '0;
            S_EX_LAST: h_ra = r_cnt[SW-1:0];
            S_DN_RD: h_ra = lch[SW-1:0];
            S_DN_LWT, S_DN_RWT: h_ra = rch[SW-1:0];
            S_DN_CMP: begin
                h_we = 1'b1; h_wa = r_s;
                p_we = 1'b1;
                if (r_has_l && r_l[CW-1:0] < r_cur_c &&
                    !(r_has_r && h_rc < r_l[CW-1:0])) begin
                    h_wd = r_l; p_wa = r_l[NW+CW-1:CW];
                end else if (r_has_r && h_rc < r_cur_c) begin
                    h_wd = h_rd; p_wa = h_rn;
                end else begin
                    h_wd = {r_cur_n, r_cur_c}; p_wa = r_cur_n;
                end
            end
            default: ;
        endcase
        // extract: old root goes to slot count, its map entry follows
        if (r_state == S_EX_SWAP) begin
            h_wa = r_cnt[SW-1:0]; h_wd = r_oth;
            p_we = 1'b1; p_wa = r_oth[NW+CW-1:CW]; p_wd = r_cnt[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_ncfg <= KW'(imh_pkg::MAX_NODES);
            r_cnt <= '0;
            r_ov <= 1'b0;
            r_req <= imh_pkg::REQ_QUERY;
        end else begin
            if (i_cfg_we) r_ncfg <= i_cfg_wdata;
            if (r_state == S_OUT && (!r_ov || !i_stall)) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    // sweep after an init request ends with its result
                    if (r_clr == KW'(imh_pkg::MAX_NODES - 1))
                        r_state <= (r_req == imh_pkg::REQ_INIT) ? S_OUT : S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_req <= i_req_type; r_id <= i_node_id; r_cost <= i_new_cost;
                        r_on <= '0; r_oc <= '0; r_of <= 1'b0; r_or <= 1'b0;
                        unique case (i_req_type)
                            imh_pkg::REQ_INIT: begin
                                r_cnt <= (r_ncfg > KW'(imh_pkg::MAX_NODES)) ?
                                         KW'(imh_pkg::MAX_NODES) : r_ncfg;
                                r_clr <= '0;
                                r_state <= S_CLR;
                            end
                            imh_pkg::REQ_EXT: r_state <= (r_cnt == '0) ? S_OUT : S_EX_RD;
                            default: r_state <= S_POS_WT;
                        endcase
                    end
                end
                S_POS_WT: begin
                    if ({1'b0, p_rd} < r_cnt) begin
                        if (r_req == imh_pkg::REQ_QUERY) begin
                            r_of <= 1'b1; r_state <= S_OUT;
                        end else begin
                            r_s <= p_rd; r_cur_n <= r_id; r_cur_c <= r_cost;
                            r_state <= S_UP_RD;
                        end
                    end else begin
                        r_or <= (r_req == imh_pkg::REQ_DEC);
                        r_state <= S_OUT;
                    end
                end
                S_UP_RD: r_state <= (r_s == '0) ? S_UP_CMP : S_UP_WT;
                S_UP_WT: r_state <= S_UP_CMP;
                S_UP_CMP: begin
                    if (r_s != '0 && h_rc > r_cur_c) begin
                        r_s <= par; r_state <= S_UP_RD;
                    end else r_state <= S_OUT;
                end
                S_EX_RD: r_state <= S_EX_WT;
                S_EX_WT: begin
                    r_oth <= h_rd; r_on <= h_rn; r_oc <= h_rc; r_of <= 1'b1;
                    r_cnt <= r_cnt - 1'b1;
                    r_state <= S_EX_LAST;
                end
                S_EX_LAST: r_state <= S_EX_LWT;
                S_EX_LWT: begin
                    r_cur_n <= h_rn; r_cur_c <= h_rc; r_s <= '0;
                    r_state <= S_EX_SWAP;
                end
                S_EX_SWAP: r_state <= S_DN_RD;
                S_DN_RD: begin
                    r_has_l <= lch < r_cnt;
                    r_has_r <= rch < r_cnt;
                    r_state <= S_DN_LWT;
                end
                S_DN_LWT: begin r_l <= h_rd; r_state <= S_DN_RWT; end
                S_DN_RWT: r_state <= S_DN_CMP;
                S_DN_CMP: begin
                    if (r_has_l && r_l[CW-1:0] < r_cur_c &&
                        !(r_has_r && h_rc < r_l[CW-1:0])) begin
                        r_s <= lch[SW-1:0]; r_state <= S_DN_RD;
                    end else if (r_has_r && h_rc < r_cur_c) begin
                        r_s <= rch[SW-1:0]; r_state <= S_DN_RD;
                    end else r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || !i_stall) begin
                        r_oe <= (r_cnt == '0);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
